// ===== hdl/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for the depth pixel back-projection unit
// Widths of the pixel and point fields, register indexes, channel order codes
// and the stage-load control group passed from the top level to each lane.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // Largest pixel index plus one; indexes at or above it are clamped.
  localparam int MAX_DIMENSION = 4096;

  localparam int IDX_W      = 12;
  localparam int DEPTH_W    = 16;
  localparam int CENTRE_W   = 16;
  localparam int SCALE_W    = 32;
  localparam int UNIT_W     = 32;
  localparam int COORD_W    = 32;
  localparam int Z_W        = 24;
  localparam int BYTE_W     = 8;
  localparam int COLOUR_W   = 3 * BYTE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ORDER_W    = 2;

  // Fixed-point alignment: lateral products carry 2^-52 m, z products 2^-32 m.
  localparam int LAT_SHIFT = 36;
  localparam int Z_SHIFT   = 16;

  // Register reset values
  localparam logic [CENTRE_W-1:0] PRINCIPAL_X_RST = 16'd5120;
  localparam logic [CENTRE_W-1:0] PRINCIPAL_Y_RST = 16'd3840;
  localparam logic [SCALE_W-1:0]  LATERAL_RST     = 32'd536119800;
  localparam logic [UNIT_W-1:0]   DEPTH_UNIT_RST  = 32'd4294967;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRINCIPAL_X   = 3'd0,
    REG_PRINCIPAL_Y   = 3'd1,
    REG_LATERAL_X     = 3'd2,
    REG_LATERAL_Y     = 3'd3,
    REG_DEPTH_UNIT    = 3'd4,
    REG_CHANNEL_ORDER = 3'd5
  } cfg_reg_t;

  // Order code 3 has the mono bit set and behaves as mono.
  typedef enum logic [ORDER_W-1:0] {
    CH_RGB      = 2'd0,
    CH_BGR      = 2'd1,
    CH_MONO     = 2'd2,
    CH_MONO_ALT = 2'd3
  } chan_order_t;

  // Load strobes for the four pipeline stages.
  typedef struct packed {
    logic ld_s1;
    logic ld_s2;
    logic ld_s3;
    logic ld_s4;
  } pipe_ctl_t;

endpackage

// ===== hdl/dpb_lateral.sv =====
// ----------------------------------------------------------------------------
// dpb_lateral: one lateral axis of the back-projection
// Four stages: principal point offset, offset times depth, times lateral
// scale, then floor shift with sign restore.
// ----------------------------------------------------------------------------
module dpb_lateral (
  input  logic                              clk,
  input  dpb_pkg::pipe_ctl_t                ctl,
  input  logic [dpb_pkg::IDX_W-1:0]         pos,
  input  logic [dpb_pkg::CENTRE_W-1:0]      centre,
  input  logic [dpb_pkg::DEPTH_W-1:0]       depth,
  input  logic [dpb_pkg::SCALE_W-1:0]       scale,
  output logic signed [dpb_pkg::COORD_W-1:0] coord
);
  import dpb_pkg::*;

  localparam int SUB_W  = IDX_W + 4;
  localparam int PROD_W = CENTRE_W + DEPTH_W;
  localparam int MAG_W  = PROD_W + SCALE_W;
  localparam int Q_W    = MAG_W - LAT_SHIFT + 1;

  logic [IDX_W-1:0]    pos_c;
  logic [SUB_W-1:0]    sub;
  logic                neg_nxt;
  logic [CENTRE_W-1:0] diff_nxt;
  logic [PROD_W-1:0]   prod_nxt;
  logic [MAG_W-1:0]    mag_nxt;
  logic [Q_W-1:0]      q;
  logic [COORD_W-1:0]  q_ext;
  logic [COORD_W-1:0]  coord_nxt;

  logic [CENTRE_W-1:0] diff_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic                neg1_r, neg2_r, neg3_r;
  logic [PROD_W-1:0]   prod_r;
  logic [MAG_W-1:0]    mag_r;
  logic [COORD_W-1:0]  coord_r;

  // Stage 1: clamp the index, subtract the principal point, keep sign apart
  always_comb begin
    pos_c    = (int'(pos) >= MAX_DIMENSION) ? IDX_W'(MAX_DIMENSION - 1) : pos;
    sub      = {pos_c, 4'b0000};
    neg_nxt  = centre > sub;
    diff_nxt = neg_nxt ? (centre - sub) : (sub - centre);
  end

  // Stages 2 and 3: two multiplies, each registered
  assign prod_nxt = PROD_W'(diff_r) * PROD_W'(depth_r);
  assign mag_nxt  = MAG_W'(prod_r) * MAG_W'(scale);

  // Stage 4: floor of a negative value is minus the ceiling of its magnitude
  always_comb begin
    q = Q_W'(mag_r[MAG_W-1:LAT_SHIFT]) + Q_W'(neg3_r && (mag_r[LAT_SHIFT-1:0] != '0));
    q_ext = COORD_W'(q);
    coord_nxt = neg3_r ? (COORD_W'(0) - q_ext) : q_ext;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_s1) begin
      diff_r  <= diff_nxt;
      depth_r <= depth;
      neg1_r  <= neg_nxt;
    end
    if (ctl.ld_s2) begin
      prod_r <= prod_nxt;
      neg2_r <= neg1_r;
    end
    if (ctl.ld_s3) begin
      mag_r  <= mag_nxt;
      neg3_r <= neg2_r;
    end
    if (ctl.ld_s4) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = $signed(coord_r);

endmodule

// ===== hdl/depth_pixel_backprojection_unit.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit: pinhole back-projection of depth pixels
// Turns one registered depth pixel with colour into an XYZ point in 2^-16 m
// units plus a packed 24-bit colour word.
// ----------------------------------------------------------------------------
// Usage: the unit accepts one pixel per clock while in_stall is low and returns
// one point per pixel, in order, through the four-stage pipeline of each
// lateral axis: offset, offset times depth (16x16), times lateral scale
// (32x32), then the floor shift and sign restore. Every stage has its own
// valid bit and empty stages keep filling while the output is stalled, so
// in_stall rises only when all four stages hold a point. A zero raw depth
// gives a point with point_valid low and zero coordinates; colour is packed
// regardless. Configuration writes are always taken (cfg_ready is tied high)
// and must be issued only while no pixel is in flight. There is no state
// between pixels and no clearing pass after reset.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit (
  input  logic                                clk,
  input  logic                                rst_n,

  // pixel input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dpb_pkg::IDX_W-1:0]           in_column,
  input  logic [dpb_pkg::IDX_W-1:0]           in_row,
  input  logic [dpb_pkg::DEPTH_W-1:0]         in_raw_depth,
  input  logic [dpb_pkg::BYTE_W-1:0]          in_chan_first,
  input  logic [dpb_pkg::BYTE_W-1:0]          in_chan_second,
  input  logic [dpb_pkg::BYTE_W-1:0]          in_chan_third,

  // point output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dpb_pkg::COORD_W-1:0]  out_point_x,
  output logic signed [dpb_pkg::COORD_W-1:0]  out_point_y,
  output logic [dpb_pkg::Z_W-1:0]             out_point_z,
  output logic                                out_point_valid,
  output logic [dpb_pkg::COLOUR_W-1:0]        out_packed_colour,

  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import dpb_pkg::*;

  localparam int ZPROD_W = DEPTH_W + UNIT_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CENTRE_W-1:0] principal_x_r, principal_y_r;
  logic [SCALE_W-1:0]  lateral_x_r, lateral_y_r;
  logic [UNIT_W-1:0]   depth_unit_r;
  logic [ORDER_W-1:0]  channel_order_r;
  logic                cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      principal_x_r   <= PRINCIPAL_X_RST;
      principal_y_r   <= PRINCIPAL_Y_RST;
      lateral_x_r     <= LATERAL_RST;
      lateral_y_r     <= LATERAL_RST;
      depth_unit_r    <= DEPTH_UNIT_RST;
      channel_order_r <= CH_RGB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRINCIPAL_X:   principal_x_r   <= cfg_wdata[CENTRE_W-1:0];
        REG_PRINCIPAL_Y:   principal_y_r   <= cfg_wdata[CENTRE_W-1:0];
        REG_LATERAL_X:     lateral_x_r     <= cfg_wdata[SCALE_W-1:0];
        REG_LATERAL_Y:     lateral_y_r     <= cfg_wdata[SCALE_W-1:0];
        REG_DEPTH_UNIT:    depth_unit_r    <= cfg_wdata[UNIT_W-1:0];
        REG_CHANNEL_ORDER: channel_order_r <= cfg_wdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor loads,
  // so bubbles collapse while the output is stalled.
  // --------------------------------------------------------------------------
  logic      v1_r, v2_r, v3_r, v4_r;
  logic      rdy1, rdy2, rdy3, rdy4;
  pipe_ctl_t ctl;

  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign ctl.ld_s1 = rdy1;
  assign ctl.ld_s2 = rdy2;
  assign ctl.ld_s3 = rdy3;
  assign ctl.ld_s4 = rdy4;

  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Colour packing, z path and the valid flag
  // --------------------------------------------------------------------------
  logic [COLOUR_W-1:0] colour_nxt;

  // Mono code 3 shares the mono arm: every channel takes the first byte.
  always_comb begin
    case (chan_order_t'(channel_order_r)) inside
      CH_BGR:               colour_nxt = {in_chan_third, in_chan_second, in_chan_first};
      CH_MONO, CH_MONO_ALT: colour_nxt = {in_chan_first, in_chan_first, in_chan_first};
      default:              colour_nxt = {in_chan_first, in_chan_second, in_chan_third};
    endcase
  end

  logic [DEPTH_W-1:0]  depth1_r;
  logic                nz1_r, nz2_r, nz3_r, nz4_r;
  logic [COLOUR_W-1:0] colour1_r, colour2_r, colour3_r, colour4_r;
  logic [ZPROD_W-1:0]  zprod_nxt, zprod2_r;
  logic [Z_W-1:0]      z3_nxt, z3_r, z4_r;

  assign zprod_nxt = ZPROD_W'(depth1_r) * ZPROD_W'(depth_unit_r);

  // Saturate when any bit above the 24-bit z field is set after the shift.
  always_comb begin
    if (zprod2_r[ZPROD_W-1:Z_SHIFT+Z_W] != '0) begin
      z3_nxt = '1;
    end else begin
      z3_nxt = zprod2_r[Z_SHIFT+Z_W-1:Z_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_s1) begin
      depth1_r  <= in_raw_depth;
      nz1_r     <= in_raw_depth != '0;
      colour1_r <= colour_nxt;
    end
    if (ctl.ld_s2) begin
      zprod2_r  <= zprod_nxt;
      nz2_r     <= nz1_r;
      colour2_r <= colour1_r;
    end
    if (ctl.ld_s3) begin
      z3_r      <= z3_nxt;
      nz3_r     <= nz2_r;
      colour3_r <= colour2_r;
    end
    if (ctl.ld_s4) begin
      z4_r      <= z3_r;
      nz4_r     <= nz3_r;
      colour4_r <= colour3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Lateral axes; a zero depth drives both products, and so x and y, to zero
  // --------------------------------------------------------------------------
  dpb_lateral u_lat_x (
    .clk    (clk),
    .ctl    (ctl),
    .pos    (in_column),
    .centre (principal_x_r),
    .depth  (in_raw_depth),
    .scale  (lateral_x_r),
    .coord  (out_point_x)
  );

  dpb_lateral u_lat_y (
    .clk    (clk),
    .ctl    (ctl),
    .pos    (in_row),
    .centre (principal_y_r),
    .depth  (in_raw_depth),
    .scale  (lateral_y_r),
    .coord  (out_point_y)
  );

  assign out_valid         = v4_r;
  assign out_point_z       = z4_r;
  assign out_point_valid   = nz4_r;
  assign out_packed_colour = colour4_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // An invalid point leaves the pipeline with all coordinates zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_point_valid) |->
      (out_point_x == '0 && out_point_y == '0 && out_point_z == '0))
    else $error("invalid point with nonzero coordinates");

  // Input backpressure only when every stage is occupied and the output stalls.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_stall))
    else $error("input stalled with a free pipeline stage");

  // An accepted pixel always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted pixel lost at stage one");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for depth_pixel_backprojection_unit
// Streams depth pixels through the unit under several register settings and
// compares every returned point, field by field, with a bit-exact prediction
// of the pinhole back-projection. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import dpb_pkg::*;

  // Registers 6 and 7 decode to nothing; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] FIRST_UNMAPPED_REG = 3'd6;
  localparam logic [CFG_IDX_W-1:0] LAST_UNMAPPED_REG  = 3'd7;

  localparam int PIPE_LATENCY      = 4;
  localparam int LONG_HOLD_CYCLES  = 80;
  localparam int RANDOM_PHASES     = 8;
  localparam int PHASE_PIXELS      = 205;
  localparam int DRAIN_LIMIT       = 5000;
  localparam int MAX_PRINTED       = 40;
  localparam int TIMEOUT           = 400000;

  typedef struct {
    logic [IDX_W-1:0]   column;
    logic [IDX_W-1:0]   row;
    logic [DEPTH_W-1:0] raw_depth;
    logic [BYTE_W-1:0]  chan_first;
    logic [BYTE_W-1:0]  chan_second;
    logic [BYTE_W-1:0]  chan_third;
  } pixel_t;

  typedef struct {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [Z_W-1:0]      z;
    logic                valid;
    logic [COLOUR_W-1:0] colour;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [IDX_W-1:0]            in_column = '0;
  logic [IDX_W-1:0]            in_row = '0;
  logic [DEPTH_W-1:0]          in_raw_depth = '0;
  logic [BYTE_W-1:0]           in_chan_first = '0;
  logic [BYTE_W-1:0]           in_chan_second = '0;
  logic [BYTE_W-1:0]           in_chan_third = '0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [COORD_W-1:0]   out_point_x;
  logic signed [COORD_W-1:0]   out_point_y;
  logic [Z_W-1:0]              out_point_z;
  logic                        out_point_valid;
  logic [COLOUR_W-1:0]         out_packed_colour;

  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata = '0;

  depth_pixel_backprojection_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_column         (in_column),
    .in_row            (in_row),
    .in_raw_depth      (in_raw_depth),
    .in_chan_first     (in_chan_first),
    .in_chan_second    (in_chan_second),
    .in_chan_third     (in_chan_third),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_point_z       (out_point_z),
    .out_point_valid   (out_point_valid),
    .out_packed_colour (out_packed_colour),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the camera registers, kept in step with every write.
  logic [CENTRE_W-1:0] centre_col       = PRINCIPAL_X_RST;
  logic [CENTRE_W-1:0] centre_row       = PRINCIPAL_Y_RST;
  logic [SCALE_W-1:0]  scale_col        = LATERAL_RST;
  logic [SCALE_W-1:0]  scale_row        = LATERAL_RST;
  logic [UNIT_W-1:0]   metres_per_count = DEPTH_UNIT_RST;
  chan_order_t         colour_order     = CH_RGB;

  pixel_t pending_pixels[$];   // filled by the sequencer, drained by the driver
  point_t expected_points[$];  // predicted at each input transfer, oldest first
  pixel_t offered;

  // Knobs set by the sequencer between or during phases.
  int send_idle_max = 0;
  int recv_idle_max = 0;
  bit sender_paused = 1'b0;
  int hold_requests = 0;

  int send_gap = 0;
  int recv_wait = 0;
  int hold_left = 0;
  int hold_served = 0;

  int mismatches = 0;
  int pixels_sent = 0;
  int points_checked = 0;
  int zero_depth_points = 0;
  int saturated_points = 0;
  int register_writes = 0;
  int settings_used = 1;
  int long_holds = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  // floor((pos*16 - centre) * depth * scale / 2^36). Taking the bits above
  // the shift of a two's complement product is already a floor division.
  function automatic logic [COORD_W-1:0] lateral_offset(
    input logic [IDX_W-1:0]    pos,
    input logic [CENTRE_W-1:0] centre,
    input logic [DEPTH_W-1:0]  depth,
    input logic [SCALE_W-1:0]  scale
  );
    logic signed [18:0] offset;
    logic signed [71:0] product;
    offset  = $signed({3'b000, pos, 4'b0000}) - $signed({3'b000, centre});
    product = offset * $signed({1'b0, depth}) * $signed({1'b0, scale});
    return product[LAT_SHIFT +: COORD_W];
  endfunction

  function automatic point_t project_pixel(input pixel_t p);
    point_t             pt;
    logic [IDX_W-1:0]   u;
    logic [IDX_W-1:0]   v;
    logic [47:0]        z_full;
    // Clamp indexes past the frame edge to the last column or row.
    u = (p.column >= MAX_DIMENSION) ? IDX_W'(MAX_DIMENSION - 1) : p.column;
    v = (p.row >= MAX_DIMENSION) ? IDX_W'(MAX_DIMENSION - 1) : p.row;
    if (p.raw_depth == '0) begin
      pt.x = '0;
      pt.y = '0;
      pt.z = '0;
      pt.valid = 1'b0;
    end else begin
      z_full = p.raw_depth * metres_per_count;
      z_full = z_full >> Z_SHIFT;
      pt.z = ((z_full >> Z_W) != 0) ? '1 : z_full[Z_W-1:0];
      pt.x = lateral_offset(u, centre_col, p.raw_depth, scale_col);
      pt.y = lateral_offset(v, centre_row, p.raw_depth, scale_row);
      pt.valid = 1'b1;
    end
    // Colour is packed even for points without depth.
    case (colour_order)
      CH_RGB:  pt.colour = {p.chan_first, p.chan_second, p.chan_third};
      CH_BGR:  pt.colour = {p.chan_third, p.chan_second, p.chan_first};
      default: pt.colour = {3{p.chan_first}};
    endcase
    return pt;
  endfunction

  // Pixel driver: offer the next pending pixel after the drawn gap, hold the
  // payload while stalled, predict the point at each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_points.push_back(project_pixel(offered));
        if (!expected_points[$].valid)
          zero_depth_points++;
        else if (expected_points[$].z == '1)
          saturated_points++;
        pixels_sent++;
        send_gap = $urandom_range(0, send_idle_max);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0 && !sender_paused) begin
          offered = pending_pixels.pop_front();
          in_valid       <= 1'b1;
          in_column      <= offered.column;
          in_row         <= offered.row;
          in_raw_depth   <= offered.raw_depth;
          in_chan_first  <= offered.chan_first;
          in_chan_second <= offered.chan_second;
          in_chan_third  <= offered.chan_third;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Point monitor: check each transfer against the oldest prediction, then
  // draw the stall for the next point. A long hold requested by the
  // sequencer is counted out here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("point with no pixel pending, x=%h y=%h z=%h",
                                    out_point_x, out_point_y, out_point_z));
        end else begin
          point_t want;
          want = expected_points.pop_front();
          if (out_point_x !== want.x)
            report_mismatch($sformatf("point %0d x got %h want %h",
                                      points_checked, out_point_x, want.x));
          if (out_point_y !== want.y)
            report_mismatch($sformatf("point %0d y got %h want %h",
                                      points_checked, out_point_y, want.y));
          if (out_point_z !== want.z)
            report_mismatch($sformatf("point %0d z got %h want %h",
                                      points_checked, out_point_z, want.z));
          if (out_point_valid !== want.valid)
            report_mismatch($sformatf("point %0d valid got %b want %b",
                                      points_checked, out_point_valid, want.valid));
          if (out_packed_colour !== want.colour)
            report_mismatch($sformatf("point %0d colour got %h want %h",
                                      points_checked, out_packed_colour, want.colour));
          points_checked++;
        end
        recv_wait = $urandom_range(0, recv_idle_max);
      end
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
        long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Write one register and mirror it into the shadow copy. Call only while
  // no pixel is in flight.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_PRINCIPAL_X:   centre_col = data[CENTRE_W-1:0];
      REG_PRINCIPAL_Y:   centre_row = data[CENTRE_W-1:0];
      REG_LATERAL_X:     scale_col = data[SCALE_W-1:0];
      REG_LATERAL_Y:     scale_row = data[SCALE_W-1:0];
      REG_DEPTH_UNIT:    metres_per_count = data[UNIT_W-1:0];
      REG_CHANNEL_ORDER: colour_order = chan_order_t'(data[ORDER_W-1:0]);
      default: ;
    endcase
    register_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Wait until every pixel is sent (or the sender is paused) and every point returned.
  task automatic wait_for_drain();
    int waited;
    waited = 0;
    while (((pending_pixels.size() != 0 && !sender_paused) || in_valid ||
            expected_points.size() != 0) && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
  endtask

  task automatic queue_pixel(input int col, input int row, input int depth,
                             input int c0, input int c1, input int c2);
    pixel_t p;
    p.column = IDX_W'(col);
    p.row = IDX_W'(row);
    p.raw_depth = DEPTH_W'(depth);
    p.chan_first = BYTE_W'(c0);
    p.chan_second = BYTE_W'(c1);
    p.chan_third = BYTE_W'(c2);
    pending_pixels.push_back(p);
  endtask

  // Field value of the given width: mostly random, sometimes all zeros or all
  // ones, with the unused upper bits of the write word scrambled.
  function automatic logic [CFG_DATA_W-1:0] random_word(input int bits);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] data;
    mask = (bits >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << bits) - 1);
    data = $urandom;
    case ($urandom_range(0, 5))
      0: data = data & ~mask;
      1: data = data | mask;
      default: ;
    endcase
    return data;
  endfunction

  function automatic logic [IDX_W-1:0] random_index();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return IDX_W'(MAX_DIMENSION - 1);
      default: return IDX_W'($urandom_range(0, MAX_DIMENSION - 1));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.column = random_index();
    p.row = random_index();
    case ($urandom_range(0, 11))
      0, 1: p.raw_depth = '0;
      2: p.raw_depth = 16'd1;
      3: p.raw_depth = '1;
      default: p.raw_depth = DEPTH_W'($urandom);
    endcase
    p.chan_first = BYTE_W'($urandom);
    p.chan_second = BYTE_W'($urandom);
    p.chan_third = BYTE_W'($urandom);
    return p;
  endfunction

  task automatic program_random_setting(input chan_order_t order);
    logic [CFG_DATA_W-1:0] order_word;
    order_word = ($urandom & ~CFG_DATA_W'(3)) | CFG_DATA_W'(order);
    write_register(REG_PRINCIPAL_X, random_word(CENTRE_W));
    write_register(REG_PRINCIPAL_Y, random_word(CENTRE_W));
    write_register(REG_LATERAL_X, random_word(SCALE_W));
    write_register(REG_LATERAL_Y, random_word(SCALE_W));
    write_register(REG_DEPTH_UNIT, random_word(UNIT_W));
    write_register(REG_CHANNEL_ORDER, order_word);
    if ($urandom_range(0, 1))
      write_register(CFG_IDX_W'($urandom_range(FIRST_UNMAPPED_REG, LAST_UNMAPPED_REG)),
                     $urandom);
    settings_used++;
  endtask

  initial begin
    #(TIMEOUT);
    $display("TEST FAILED");
    $finish;
  end

  // Sequencer
  initial begin
    int phase;
    int i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: frame corners, pixels on the principal point, one
    // column/row off it for floor rounding, zero depth with colour kept.
    @(negedge clk);
    send_idle_max = 3;
    recv_idle_max = 3;
    queue_pixel(0, 0, 1, 8'h00, 8'h00, 8'h00);
    queue_pixel(MAX_DIMENSION - 1, MAX_DIMENSION - 1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(320, 240, 1000, 8'h11, 8'h22, 8'h33);
    queue_pixel(319, 241, 1000, 8'h44, 8'h55, 8'h66);
    queue_pixel(100, 50, 0, 8'h12, 8'h34, 8'h56);
    queue_pixel(MAX_DIMENSION - 1, 0, 0, 8'hFF, 8'h00, 8'hFF);
    queue_pixel(0, MAX_DIMENSION - 1, 16'hFFFF, 8'hAA, 8'h55, 8'h0F);
    queue_pixel(MAX_DIMENSION - 1, 0, 1, 8'h01, 8'h80, 8'hFE);
    wait_for_drain();

    // All-ones extremes: z saturates, x reaches its most negative value.
    // Upper bits of the narrow registers carry junk that must be masked.
    write_register(REG_PRINCIPAL_X, 32'hABCD_FFFF);
    write_register(REG_PRINCIPAL_Y, 32'hFFFF_0000);
    write_register(REG_LATERAL_X, '1);
    write_register(REG_LATERAL_Y, '1);
    write_register(REG_DEPTH_UNIT, '1);
    write_register(REG_CHANNEL_ORDER, 32'hFFFF_FFFD);
    write_register(FIRST_UNMAPPED_REG, 32'h0000_0000);
    write_register(LAST_UNMAPPED_REG, '1);
    settings_used++;
    @(negedge clk);
    queue_pixel(0, 0, 16'hFFFF, 8'h01, 8'h02, 8'h03);
    queue_pixel(MAX_DIMENSION - 1, MAX_DIMENSION - 1, 16'hFFFF, 8'hF0, 8'h0F, 8'h99);
    queue_pixel(0, MAX_DIMENSION - 1, 1, 8'h7F, 8'h80, 8'h81);
    queue_pixel(MAX_DIMENSION - 1, MAX_DIMENSION - 1, 0, 8'h01, 8'h02, 8'h03);
    queue_pixel(2048, 2048, 32768, 8'h10, 8'h20, 8'h30);
    wait_for_drain();

    // Zero extremes, mono colour.
    write_register(REG_PRINCIPAL_X, 32'h0000_0000);
    write_register(REG_PRINCIPAL_Y, 32'h0000_FFFF);
    write_register(REG_LATERAL_X, 32'h0000_0000);
    write_register(REG_LATERAL_Y, 32'h0000_0001);
    write_register(REG_DEPTH_UNIT, 32'h0000_0000);
    write_register(REG_CHANNEL_ORDER, CFG_DATA_W'(CH_MONO));
    settings_used++;
    @(negedge clk);
    queue_pixel(MAX_DIMENSION - 1, 0, 16'hFFFF, 8'h09, 8'h08, 8'h07);
    queue_pixel(0, MAX_DIMENSION - 1, 1, 8'hFF, 8'h00, 8'h00);
    queue_pixel(5, 7, 0, 8'h3C, 8'hC3, 8'h5A);
    wait_for_drain();

    // Order code 3 falls back to mono; a unit of one count per 2^-16 m
    // makes z equal the raw depth.
    write_register(REG_DEPTH_UNIT, 32'h0001_0000);
    write_register(REG_CHANNEL_ORDER, CFG_DATA_W'(CH_MONO_ALT));
    settings_used++;
    @(negedge clk);
    queue_pixel(1, 1, 300, 8'h80, 8'h40, 8'h20);
    queue_pixel(MAX_DIMENSION - 1, MAX_DIMENSION - 1, 16'hFFFF, 8'h00, 8'hFF, 8'h00);
    wait_for_drain();

    // Random phases: rotate the channel order and the idle pattern. Phase 4
    // runs a long output hold against a sender with no gaps so the pipe
    // fills and stalls its input; phases 3 and 7 pause the sender mid-way
    // until every point is back.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_random_setting(chan_order_t'(phase % 4));
      @(negedge clk);
      send_idle_max = (phase % 2 == 1) ? 3 : 0;
      recv_idle_max = (phase % 4 >= 2) ? 3 : 0;
      for (i = 0; i < PHASE_PIXELS; i++)
        pending_pixels.push_back(random_pixel());
      if (phase == 3 || phase == 4 || phase == 7) begin
        while (pending_pixels.size() > PHASE_PIXELS / 2)
          @(negedge clk);
        if (phase == 4) begin
          hold_requests++;
        end else begin
          sender_paused = 1'b1;
          wait_for_drain();
          sender_paused = 1'b0;
        end
      end
      wait_for_drain();
    end

    // Let the pipeline settle, then flag anything never returned.
    wait_for_drain();
    repeat (2 * PIPE_LATENCY) @(negedge clk);
    if (expected_points.size() != 0)
      report_mismatch($sformatf("%0d predicted points never returned",
                                expected_points.size()));

    $display("Projected %0d pixels, checked %0d points across %0d register settings",
             pixels_sent, points_checked, settings_used);
    $display("(%0d writes), %0d zero-depth points, %0d saturated z, %0d long holds",
             register_writes, zero_depth_points, saturated_points, long_holds);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
